>>> rtl/core/iprt_pkg.sv
// Shared types, codes and defaults for the IPv4 port rule table.
`default_nettype none
package iprt_pkg;

  localparam int unsigned RULES_DEF = 16;
  localparam int unsigned POS_W     = 4;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_CHECK    = 2'd1;
  localparam logic [1:0] OP_DELETE   = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_ACCEPTED  = 3'd2;
  localparam logic [2:0] ST_REJECTED  = 3'd3;
  localparam logic [2:0] ST_DELETED   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;
  localparam logic [2:0] ST_ILLEGAL   = 3'd7;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr_low;
    logic [31:0] addr_high;
    logic        addr_is_range;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic        port_is_range;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [POS_W-1:0] match_position;
  } res_t;

  typedef struct packed {
    logic [31:0] addr_low;
    logic [31:0] addr_high;
    logic        addr_range;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic        port_range;
  } entry_t;

  typedef struct packed {
    logic hit;   // connection falls inside the rule
    logic same;  // rule equals the request in form and values
  } match_t;

endpackage
`default_nettype wire

>>> rtl/core/iprt_match.sv
// Shared compare unit: tests one stored rule against the held request.
`default_nettype none
module iprt_match (
  input  wire iprt_pkg::entry_t ent_i,
  input  wire iprt_pkg::entry_t req_i,
  output iprt_pkg::match_t match_o
);

  logic addr_hit;
  logic port_hit;

  always_comb begin
    if (ent_i.addr_range) begin
      addr_hit = (req_i.addr_low >= ent_i.addr_low) && (req_i.addr_low <= ent_i.addr_high);
    end else begin
      addr_hit = (req_i.addr_low == ent_i.addr_low);
    end
    if (ent_i.port_range) begin
      port_hit = (req_i.port_low >= ent_i.port_low) && (req_i.port_low <= ent_i.port_high);
    end else begin
      port_hit = (req_i.port_low == ent_i.port_low);
    end
  end

  assign match_o.hit  = addr_hit && port_hit;
  assign match_o.same = (ent_i == req_i);

endmodule
`default_nettype wire

>>> rtl/core/ip_port_rule_table.sv
// Top level of the IPv4 address/port rule table with its scan sequencer.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+---------------------
//  request   | in        | start high, busy low  | req_i  (iprt_pkg::req_t)
//  result    | out       | done_o, one cycle     | res_o  (iprt_pkg::res_t)
//
// Flow: add, invalid and illegal requests, and a check or delete on an empty
// table, give their result in the cycle after the item is taken. A check reads
// one stored rule per cycle through a single memory read port, newest first,
// and reports when a rule hits or all rules are read. A delete scans the same
// way and then compacts the rules above the removed one, one rule moved per
// cycle through the same port pair.
// Reset clears the rule count and the sequencer; rule storage is not cleared.
// busy is high while a scan or compaction runs; the result cannot be stalled.
`default_nettype none
module ip_port_rule_table #(
  parameter int unsigned RULES = iprt_pkg::RULES_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  input  wire iprt_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output iprt_pkg::res_t res_o
);

  localparam int unsigned IW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int unsigned CW = $clog2(RULES + 1);
  localparam int unsigned AW = (CW > iprt_pkg::POS_W) ? CW : iprt_pkg::POS_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    ptr_q, ptr_d;
  logic             more_q, more_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IW-1:0]    slot_q;
  logic             op_del_q, op_del_d;
  iprt_pkg::entry_t key_q, key_d;
  iprt_pkg::entry_t rd_q;
  logic             done_q, done_d;
  iprt_pkg::res_t   res_q, res_d;
  logic [iprt_pkg::POS_W-1:0] pos_q, pos_d;

  iprt_pkg::entry_t mem [RULES];
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  iprt_pkg::entry_t wr_data;

  logic             accept;
  logic             req_valid;
  logic             oct_bad;
  logic [IW-1:0]    last_slot;
  logic [AW-1:0]    age;
  logic [iprt_pkg::POS_W-1:0] age_pos;
  iprt_pkg::entry_t req_key;
  iprt_pkg::match_t match;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  assign last_slot = IW'(cnt_q - CW'(1));
  assign age       = AW'(cnt_q) - AW'(1) - AW'(slot_q);
  assign age_pos   = age[iprt_pkg::POS_W-1:0];

  // Normalize the request: drop the high values of single fields.
  always_comb begin
    req_key.addr_low   = req_i.addr_low;
    req_key.addr_high  = req_i.addr_is_range ? req_i.addr_high : 32'd0;
    req_key.addr_range = req_i.addr_is_range;
    req_key.port_low   = req_i.port_low;
    req_key.port_high  = req_i.port_is_range ? req_i.port_high : 16'd0;
    req_key.port_range = req_i.port_is_range;
  end

  // Rule check: octets of a range start must not pass the end octets,
  // a port range must be strictly increasing.
  always_comb begin
    oct_bad = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (req_i.addr_low[8*k +: 8] > req_i.addr_high[8*k +: 8]) begin
        oct_bad = 1'b1;
      end
    end
    req_valid = !(req_i.addr_is_range && oct_bad) &&
                !(req_i.port_is_range && (req_i.port_high <= req_i.port_low));
  end

  iprt_match u_match (
    .ent_i   (rd_q),
    .req_i   (key_q),
    .match_o (match)
  );

  // Sequencer: one rule read per cycle; the compare is made in the cycle after the read.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    more_d   = more_q;
    rd_vld_d = 1'b0;
    op_del_d = op_del_q;
    key_d    = key_q;
    pos_d    = pos_q;
    done_d   = 1'b0;
    res_d    = res_q;
    wr_en    = 1'b0;
    wr_addr  = IW'(cnt_q);
    wr_data  = req_key;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d    = req_key;
          op_del_d = (req_i.op == iprt_pkg::OP_DELETE);
          ptr_d    = last_slot;
          more_d   = 1'b1;
          done_d   = 1'b1;
          res_d.match_position = '0;
          res_d.status         = iprt_pkg::ST_ILLEGAL;
          unique case (req_i.op)
            iprt_pkg::OP_ADD: begin
              if (!req_valid) begin
                res_d.status = iprt_pkg::ST_INVALID;
              end else if (cnt_q == CW'(RULES)) begin
                res_d.status = iprt_pkg::ST_FULL;
              end else begin
                wr_en        = 1'b1;
                cnt_d        = cnt_q + CW'(1);
                res_d.status = iprt_pkg::ST_ADDED;
              end
            end
            iprt_pkg::OP_CHECK: begin
              if (req_i.addr_is_range || req_i.port_is_range) begin
                res_d.status = iprt_pkg::ST_ILLEGAL;
              end else if (cnt_q == '0) begin
                res_d.status = iprt_pkg::ST_REJECTED;
              end else begin
                done_d  = 1'b0;
                state_d = S_SCAN;
              end
            end
            iprt_pkg::OP_DELETE: begin
              if (!req_valid) begin
                res_d.status = iprt_pkg::ST_INVALID;
              end else if (cnt_q == '0) begin
                res_d.status = iprt_pkg::ST_NOT_FOUND;
              end else begin
                done_d  = 1'b0;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_d.status = iprt_pkg::ST_ILLEGAL;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read, newest to oldest.
        if (more_q) begin
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q - IW'(1);
          more_d   = (ptr_q != '0);
        end
        if (rd_vld_q && !op_del_q && match.hit) begin
          rd_vld_d             = 1'b0;
          done_d               = 1'b1;
          res_d.status         = iprt_pkg::ST_ACCEPTED;
          res_d.match_position = age_pos;
          state_d              = S_IDLE;
        end else if (rd_vld_q && op_del_q && match.same) begin
          rd_vld_d = 1'b0;
          pos_d    = age_pos;
          if (slot_q == last_slot) begin
            // Newest rule removed: no compaction needed.
            cnt_d                = cnt_q - CW'(1);
            done_d               = 1'b1;
            res_d.status         = iprt_pkg::ST_DELETED;
            res_d.match_position = age_pos;
            state_d              = S_IDLE;
          end else begin
            ptr_d   = slot_q + IW'(1);
            more_d  = 1'b1;
            state_d = S_SHIFT;
          end
        end else if (rd_vld_q && !more_q) begin
          rd_vld_d             = 1'b0;
          done_d               = 1'b1;
          res_d.match_position = '0;
          res_d.status         = op_del_q ? iprt_pkg::ST_NOT_FOUND : iprt_pkg::ST_REJECTED;
          state_d              = S_IDLE;
        end
      end

      S_SHIFT: begin
        // Read slot k+1, then write it back one slot lower.
        if (more_q) begin
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + IW'(1);
          more_d   = (ptr_q != last_slot);
        end
        if (rd_vld_q) begin
          wr_en   = 1'b1;
          wr_addr = slot_q - IW'(1);
          wr_data = rd_q;
          if (!more_q) begin
            rd_vld_d             = 1'b0;
            cnt_d                = cnt_q - CW'(1);
            done_d               = 1'b1;
            res_d.status         = iprt_pkg::ST_DELETED;
            res_d.match_position = pos_q;
            state_d              = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      more_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      more_q   <= more_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    slot_q   <= ptr_q;
    op_del_q <= op_del_d;
    key_q    <= key_d;
    pos_q    <= pos_d;
    res_q    <= res_d;
  end

  // Rule storage: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[ptr_q];
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(RULES))
    else $error("rule count above table size");

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !rd_vld_q)
    else $error("read data pending while idle");

  a_add_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.op == iprt_pkg::OP_ADD)) |=> done_q)
    else $error("add result not given in the next cycle");

  a_del_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status == iprt_pkg::ST_DELETED)) |-> (cnt_q + CW'(1) == $past(cnt_q)))
    else $error("delete did not remove exactly one rule");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status == iprt_pkg::ST_ADDED)) |-> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("add did not store exactly one rule");

endmodule
`default_nettype wire
